// ===== rtl/imp_pkg.sv =====
// Shared types and constants of the integer matrix power block.
// Used by imp_mac, integer_matrix_power_top and the testbench; depends on nothing else.
package imp_pkg;

  // Width of matrix elements and of the arithmetic, which wraps at this width.
  localparam int DATA_BITS = 32;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam int SIZE_BITS      = 4;
  localparam int EXP_BITS       = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MATRIX_SIZE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT    = 1'd1;

  // Load position and its split into row and column by reciprocal multiply.
  localparam int LOAD_COUNT_BITS = 7;
  localparam int LOAD_INDEX_BITS = 6;
  localparam int RECIP_SHIFT     = 10;
  localparam int RECIP_BITS      = 11;

  // Where the result words come from.
  typedef enum logic [1:0] {
    SRC_IDENT = 2'd0,
    SRC_WORK  = 2'd1,
    SRC_PROD  = 2'd2
  } out_src_t;

  // Control that travels with one multiply through the MAC pipeline.
  typedef struct packed {
    logic first;   // first term of a dot product
    logic last_k;  // last term; the sum is written back
  } mac_ctl_t;

  // ceil(2^RECIP_SHIFT / n) for n = 1..8; exact quotient for dividends below 64.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [SIZE_BITS-1:0] n);
    logic [RECIP_BITS-1:0] r;
    begin
      case (n)
        4'd1:    r = 11'd1024;
        4'd2:    r = 11'd512;
        4'd3:    r = 11'd342;
        4'd4:    r = 11'd256;
        4'd5:    r = 11'd205;
        4'd6:    r = 11'd171;
        4'd7:    r = 11'd147;
        4'd8:    r = 11'd128;
        default: r = 11'd1024;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/integer_matrix_power_top.sv =====
// Integer matrix power: loads a square matrix word by word and streams out
// its configured power. Depends on imp_pkg and imp_mac.
//
// Elements enter row by row, one word per cycle, while s_tready is high.
// After the last element the block computes the power in exponent - 1
// multiply passes. Each pass does one multiply-accumulate per cycle on the
// single MAC unit and then waits for its pipeline to drain, and the
// passes alternate between the work and product memories. Exponents 0 and 1
// skip the passes. The n*n result words then leave in row-major order, each
// read from memory once the word before it is accepted and then shown, with
// tlast on the final word; the next matrix is taken after that word is accepted.
// Matrix size and exponent may be changed between matrices; a size of 0 acts
// as 1 and a size above MAX_DIM acts as MAX_DIM. The memories need no
// clearing after reset.
module integer_matrix_power_top #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [imp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [imp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // Input words.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,  // [31:0] element
  // Result words.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [31:0]                         m_tdata,  // [31:0] value
  output logic                                m_tlast
);
  import imp_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_RD    = 5'b01000,
    ST_SHOW  = 5'b10000
  } state_t;

  state_t                     state;
  logic [SIZE_BITS-1:0]       matrix_size;
  logic [EXP_BITS-1:0]        exponent;
  logic [LOAD_COUNT_BITS-1:0] load_count;
  logic [EXP_BITS-1:0]        passes_left;
  logic                       parity;
  out_src_t                   out_src;
  logic [DW-1:0]              row;
  logic [DW-1:0]              col;
  logic [DW-1:0]              kk;

  logic [DATA_BITS-1:0] source_store  [CELLS];
  logic [DATA_BITS-1:0] work_store    [CELLS];
  logic [DATA_BITS-1:0] product_store [CELLS];
  logic [DATA_BITS-1:0] source_rd;
  logic [DATA_BITS-1:0] work_rd;
  logic [DATA_BITS-1:0] product_rd;

  logic [SIZE_BITS-1:0]       n;
  logic [SIZE_BITS-1:0]       nm1;
  logic [LOAD_COUNT_BITS-1:0] total;
  logic [LOAD_COUNT_BITS-1:0] load_count_next;
  logic                       load_done;
  logic                       in_accept;
  logic                       out_accept;

  logic [LOAD_INDEX_BITS-1:0] ld_idx;
  logic [16:0]                ld_quot_w;
  logic [LOAD_COUNT_BITS-1:0] ld_row;
  logic [9:0]                 ld_back;
  logic [LOAD_INDEX_BITS-1:0] ld_col;
  logic [9:0]                 ld_addr_w;
  logic                       ld_store;

  logic          row_last;
  logic          col_last;
  logic          k_last;
  logic [AW-1:0] left_addr;
  logic [AW-1:0] right_addr;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] rd_addr;

  mac_ctl_t             issue_ctl;
  logic                 mac_issue;
  logic                 mac_busy;
  logic                 wb_en;
  logic [AW-1:0]        wb_addr;
  logic [DATA_BITS-1:0] wb_data;
  logic [DATA_BITS-1:0] left_op;

  // Size in force, clamped to 1..MAX_DIM.
  always_comb begin
    if (matrix_size == '0) begin
      n = SIZE_BITS'(1);
    end else if (matrix_size > SIZE_BITS'(MAX_DIM)) begin
      n = SIZE_BITS'(MAX_DIM);
    end else begin
      n = matrix_size;
    end
  end

  assign nm1             = n - SIZE_BITS'(1);
  assign total           = LOAD_COUNT_BITS'(n) * LOAD_COUNT_BITS'(n);
  assign load_count_next = load_count + LOAD_COUNT_BITS'(1);
  assign load_done       = load_count_next >= total;
  assign in_accept       = s_tvalid & s_tready;
  assign out_accept      = m_tvalid & m_tready;

  // Row-major load position split into row and column for the size in force.
  assign ld_idx    = load_count[LOAD_INDEX_BITS-1:0];
  assign ld_quot_w = 17'(ld_idx) * 17'(recip(n));
  assign ld_row    = ld_quot_w[16:RECIP_SHIFT];
  assign ld_back   = 10'(ld_row) * 10'(n);
  assign ld_col    = ld_idx - ld_back[LOAD_INDEX_BITS-1:0];
  assign ld_addr_w = 10'(ld_row) * 10'(MAX_DIM) + 10'(ld_col);
  assign ld_store  = (LOAD_COUNT_BITS'(ld_idx) < LOAD_COUNT_BITS'(CELLS))
                   && (ld_row < LOAD_COUNT_BITS'(MAX_DIM));

  assign row_last   = SIZE_BITS'(row) == nm1;
  assign col_last   = SIZE_BITS'(col) == nm1;
  assign k_last     = SIZE_BITS'(kk) == nm1;
  assign left_addr  = AW'(AW'(row) * AW'(MAX_DIM) + AW'(kk));
  assign right_addr = AW'(AW'(kk) * AW'(MAX_DIM) + AW'(col));
  assign cell_addr  = AW'(AW'(row) * AW'(MAX_DIM) + AW'(col));
  assign rd_addr    = (state == ST_MUL) ? left_addr : cell_addr;

  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_SHOW);
  assign m_tlast  = row_last & col_last;

  always_comb begin
    case (out_src)
      SRC_IDENT: m_tdata = (row == col) ? 32'd1 : 32'd0;
      SRC_WORK:  m_tdata = work_rd;
      SRC_PROD:  m_tdata = product_rd;
      default:   m_tdata = work_rd;
    endcase
  end

  // Memories. Loading writes both source and work, so the first pass finds
  // the matrix in work as its left operand.
  always_ff @(posedge clk) begin
    if (in_accept && ld_store) begin
      source_store[AW'(ld_addr_w)] <= s_tdata;
    end
    source_rd <= source_store[right_addr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && ld_store) begin
      work_store[AW'(ld_addr_w)] <= s_tdata;
    end else if (wb_en && parity) begin
      work_store[wb_addr] <= wb_data;
    end
    work_rd <= work_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wb_en && !parity) begin
      product_store[wb_addr] <= wb_data;
    end
    product_rd <= product_store[rd_addr];
  end

  // Even passes multiply work into product, odd passes product into work.
  assign mac_issue       = (state == ST_MUL);
  assign issue_ctl.first  = (kk == '0);
  assign issue_ctl.last_k = k_last;
  assign left_op         = parity ? product_rd : work_rd;

  imp_mac #(
    .AW (AW)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     (mac_issue),
    .issue_ctl (issue_ctl),
    .issue_dst (cell_addr),
    .a         (left_op),
    .b         (source_rd),
    .busy      (mac_busy),
    .wr_en     (wb_en),
    .wr_addr   (wb_addr),
    .wr_data   (wb_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_BITS'(1);
      exponent    <= EXP_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATRIX_SIZE: matrix_size <= cfg_data[SIZE_BITS-1:0];
        CFG_EXPONENT:    exponent    <= cfg_data[EXP_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      load_count  <= '0;
      passes_left <= '0;
      parity      <= 1'b0;
      out_src     <= SRC_WORK;
      row         <= '0;
      col         <= '0;
      kk          <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (!load_done) begin
              load_count <= load_count_next;
            end else begin
              load_count  <= '0;
              row         <= '0;
              col         <= '0;
              kk          <= '0;
              parity      <= 1'b0;
              passes_left <= exponent - EXP_BITS'(1);
              if (exponent == '0) begin
                out_src <= SRC_IDENT;
                state   <= ST_RD;
              end else if (exponent == EXP_BITS'(1)) begin
                out_src <= SRC_WORK;
                state   <= ST_RD;
              end else begin
                state <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          if (k_last) begin
            kk <= '0;
            if (col_last) begin
              col <= '0;
              if (row_last) begin
                row   <= '0;
                state <= ST_DRAIN;
              end else begin
                row <= row + DW'(1);
              end
            end else begin
              col <= col + DW'(1);
            end
          end else begin
            kk <= kk + DW'(1);
          end
        end
        ST_DRAIN: begin
          // The next pass reads what this one wrote, so wait for the last write.
          if (!mac_busy) begin
            if (passes_left == EXP_BITS'(1)) begin
              out_src <= parity ? SRC_WORK : SRC_PROD;
              state   <= ST_RD;
            end else begin
              passes_left <= passes_left - EXP_BITS'(1);
              parity      <= ~parity;
              state       <= ST_MUL;
            end
          end
        end
        ST_RD: begin
          state <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_accept) begin
            if (row_last && col_last) begin
              row   <= '0;
              col   <= '0;
              state <= ST_LOAD;
            end else begin
              if (col_last) begin
                col <= '0;
                row <= row + DW'(1);
              end else begin
                col <= col + DW'(1);
              end
              state <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== rtl/imp_mac.sv =====
// Multiply-accumulate pipeline of the integer matrix power block.
// Takes an issue the cycle before its operands arrive (memory read latency)
// and returns one write-back per finished dot product. Depends on imp_pkg.
module imp_mac #(
  parameter int AW = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           issue,
  input  imp_pkg::mac_ctl_t              issue_ctl,
  input  logic [AW-1:0]                  issue_dst,
  input  logic [imp_pkg::DATA_BITS-1:0]  a,
  input  logic [imp_pkg::DATA_BITS-1:0]  b,
  output logic                           busy,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [imp_pkg::DATA_BITS-1:0]  wr_data
);
  import imp_pkg::*;

  logic                 p1_valid;
  logic                 p2_valid;
  mac_ctl_t             p1_ctl;
  mac_ctl_t             p2_ctl;
  logic [AW-1:0]        p1_dst;
  logic [AW-1:0]        p2_dst;
  logic [DATA_BITS-1:0] mul_q;
  logic [DATA_BITS-1:0] acc;
  logic [DATA_BITS-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
    end
  end

  // The low word of the product is the same for signed and unsigned operands.
  always_ff @(posedge clk) begin
    p1_ctl <= issue_ctl;
    p1_dst <= issue_dst;
    p2_ctl <= p1_ctl;
    p2_dst <= p1_dst;
    mul_q  <= a * b;
    if (p2_valid) begin
      acc <= sum;
    end
  end

  assign sum     = p2_ctl.first ? mul_q : acc + mul_q;
  assign wr_en   = p2_valid & p2_ctl.last_k;
  assign wr_addr = p2_dst;
  assign wr_data = sum;
  assign busy    = p1_valid | p2_valid;

endmodule

// ===== tb/integer_matrix_power_checker.sv =====
// Checker for the integer matrix power block: watches the configuration port and
// both word streams, predicts each result matrix and compares it word by word.
// Depends on imp_pkg for the register indexes and field widths.
`timescale 1ns / 1ps
module integer_matrix_power_checker #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [imp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [imp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [31:0]                         s_tdata,  // [31:0] element
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [31:0]                         m_tdata,  // [31:0] value
  input  logic                                m_tlast,
  output int                                  error_count = 0,
  output int                                  pending_words = 0,
  output int                                  words_checked = 0,
  output int                                  matrices_done = 0
);
  import imp_pkg::*;

  localparam int CELLS = MAX_DIM * MAX_DIM;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } result_word_t;

  result_word_t             power_q[$];
  logic [SIZE_BITS-1:0]     size_reg;
  logic [EXP_BITS-1:0]      exp_reg;
  logic [31:0]              loaded [0:CELLS-1];
  logic [LOAD_COUNT_BITS-1:0] load_count;
  int                       fails = 0;
  int                       seen = 0;
  int                       matrices = 0;

  function automatic int active_dim(input logic [SIZE_BITS-1:0] s);
    if (s == '0) return 1;
    if (int'(s) > MAX_DIM) return MAX_DIM;
    return int'(s);
  endfunction

  // Raises the loaded matrix to the power p by repeated multiplication and
  // queues the result words in row-major order.
  function automatic void predict_power(input int n, input logic [EXP_BITS-1:0] p);
    logic [31:0]  run_m  [0:CELLS-1];
    logic [31:0]  next_m [0:CELLS-1];
    logic [31:0]  sum;
    result_word_t w;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        run_m[r*MAX_DIM+c] = (p == '0) ? ((r == c) ? 32'd1 : 32'd0) : loaded[r*MAX_DIM+c];
    for (int i = 1; i < int'(p); i++) begin
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) begin
          sum = 32'd0;
          for (int k = 0; k < n; k++)
            sum = sum + run_m[r*MAX_DIM+k] * loaded[k*MAX_DIM+c];
          next_m[r*MAX_DIM+c] = sum;
        end
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          run_m[r*MAX_DIM+c] = next_m[r*MAX_DIM+c];
    end
    for (int idx = 0; idx < n * n; idx++) begin
      w.value = run_m[(idx / n) * MAX_DIM + idx % n];
      w.last  = (idx + 1 == n * n);
      power_q.push_back(w);
    end
  endfunction

  task automatic note_failure(input string what);
    fails++;
    if (fails <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin : monitor
    result_word_t want;
    int           n;
    int           slot;
    if (rst) begin
      size_reg   = SIZE_BITS'(1);
      exp_reg    = EXP_BITS'(1);
      load_count = '0;
      power_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MATRIX_SIZE) size_reg = cfg_data[SIZE_BITS-1:0];
        else if (cfg_index == CFG_EXPONENT) exp_reg = cfg_data[EXP_BITS-1:0];
      end
      if (m_tvalid && m_tready) begin
        seen++;
        if (power_q.size() == 0) begin
          note_failure($sformatf("result word %h last %b arrived with nothing expected",
                                 m_tdata, m_tlast));
        end else begin
          want = power_q.pop_front();
          if (m_tdata !== want.value || m_tlast !== want.last)
            note_failure($sformatf("result word %0d: expected %h last %b, got %h last %b",
                                   seen, want.value, want.last, m_tdata, m_tlast));
        end
      end
      if (s_tvalid && s_tready) begin
        n    = active_dim(size_reg);
        slot = int'(load_count[LOAD_INDEX_BITS-1:0]);
        if (slot / n < MAX_DIM) loaded[(slot / n) * MAX_DIM + slot % n] = s_tdata;
        load_count = load_count + LOAD_COUNT_BITS'(1);
        if (int'(load_count) >= n * n) begin
          load_count = '0;
          predict_power(n, exp_reg);
          matrices++;
        end
      end
    end
    error_count   <= fails;
    pending_words <= power_q.size();
    words_checked <= seen;
    matrices_done <= matrices;
  end

endmodule

// ===== tb/tb_integer_matrix_power_top.sv =====
// Testbench top for the integer matrix power block: drives configuration and
// element words under several handshake regimes and reports the verdict.
// Depends on imp_pkg, integer_matrix_power_top and integer_matrix_power_checker.
`timescale 1ns / 1ps
module tb_integer_matrix_power_top;
  import imp_pkg::*;

  localparam int TOTAL_WORDS    = 410;
  localparam int DIRECTED_WORDS = 25;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  // The longest quiet stretch is the size 1, exponent 65535 matrix.
  localparam int WATCHDOG_LIMIT = 1_500_000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [31:0]               s_tdata = '0;   // [31:0] element
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [31:0]               m_tdata;        // [31:0] value
  logic                      m_tlast;

  int error_count;
  int pending_words;
  int words_checked;
  int matrices_done;
  int words_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int stall_hold = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  integer_matrix_power_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  integer_matrix_power_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .error_count   (error_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .matrices_done (matrices_done)
  );

  // Result side: a pending hold-off wins over the random stall pattern.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      m_tready <= 1'b0;
      stall_hold = stall_hold - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("No word moved for %0d cycles; %0d result words still due.",
                 quiet_cycles, pending_words);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Both registers are written on consecutive edges with the enable held high.
  task automatic write_config(input logic [SIZE_BITS-1:0] size_val,
                              input logic [EXP_BITS-1:0] exp_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MATRIX_SIZE;
    cfg_data  <= CFG_DATA_BITS'(size_val);
    @(posedge clk);
    cfg_index <= CFG_EXPONENT;
    cfg_data  <= exp_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_element(input logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_element();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return 32'($urandom_range(6)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic int dim_of(input logic [SIZE_BITS-1:0] s);
    if (s == '0) return 1;
    if (int'(s) > 8) return 8;
    return int'(s);
  endfunction

  task automatic send_matrices(input logic [SIZE_BITS-1:0] size_val, input int count);
    for (int m = 0; m < count; m++)
      for (int i = 0; i < dim_of(size_val) ** 2; i++)
        send_element(pick_element());
  endtask

  // One configuration followed by a few matrices sent back to back.
  task automatic random_group();
    logic [SIZE_BITS-1:0] size_val;
    logic [EXP_BITS-1:0]  exp_val;
    int                   pick;
    pick = $urandom_range(99);
    if (pick < 6) size_val = '0;
    else if (pick < 9) size_val = SIZE_BITS'($urandom_range(9, 15));
    else if (pick < 13) size_val = SIZE_BITS'(8);
    else size_val = SIZE_BITS'($urandom_range(1, 5));
    pick = $urandom_range(99);
    if (dim_of(size_val) >= 6) exp_val = EXP_BITS'($urandom_range(0, 6));
    else if (pick < 10) exp_val = '0;
    else if (pick < 20) exp_val = EXP_BITS'(1);
    else if (pick < 25 && dim_of(size_val) <= 2) exp_val = EXP_BITS'($urandom_range(100, 3000));
    else exp_val = EXP_BITS'($urandom_range(2, 24));
    write_config(size_val, exp_val);
    send_matrices(size_val, int'($urandom_range(1, 3)));
    wait_drained();
  endtask

  initial begin
    int idle_pct [4];
    int stall_pct [4];
    idle_pct  = '{0, 73, 0, 6};
    stall_pct = '{0, 0, 73, 6};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration is size 1, exponent 1: words come back unchanged.
    send_element(32'h7FFF_FFFF);
    send_element(32'h8000_0000);
    wait_drained();
    // Size 0 behaves as size 1; exponent 0 gives the identity.
    write_config(4'd0, 16'd0);
    send_element(-32'sd5);
    wait_drained();
    write_config(4'd1, 16'hFFFF);
    send_element(32'd3);
    wait_drained();
    // Extremes that overflow when squared.
    write_config(4'd2, 16'd2);
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'hFFFF_FFFF);
    send_element(32'h0000_0000);
    wait_drained();
    write_config(4'd3, 16'd0);
    send_matrices(4'd3, 1);
    wait_drained();
    write_config(4'd2, 16'd1);
    send_matrices(4'd2, 1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = idle_pct[ph];
      recv_stall = stall_pct[ph];
      if (ph == 0) begin
        // Size above the maximum behaves as the maximum.
        write_config(4'd15, 16'd3);
        send_matrices(4'd15, 1);
        wait_drained();
        // Long hold on the result side while the sender keeps offering words.
        write_config(4'd3, 16'd2);
        stall_hold = HOLD_CYCLES;
        send_matrices(4'd3, 3);
        wait_drained();
      end
      while (words_sent < DIRECTED_WORDS + (ph + 1) * (TOTAL_WORDS - DIRECTED_WORDS) / 4)
        random_group();
    end

    $display("Covered %0d element words in %0d matrices and %0d result words,",
             words_sent, matrices_done, words_checked);
    $display("sizes 0 to 15, exponents 0 to 65535, four handshake regimes and a long hold.");
    if (error_count == 0 && pending_words == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/imp_pkg.sv
rtl/imp_mac.sv
rtl/integer_matrix_power_top.sv
tb/integer_matrix_power_checker.sv
tb/tb_integer_matrix_power_top.sv
